// ===== rtl/fdp_pkg.sv =====
// shared types, constants and helpers for the 4d to 3d projection block
// no dependencies; every other file of the block depends on this package
`default_nettype none
package fdp_pkg;
  localparam int MAX_DIMS   = 8;
  localparam int COORD_BITS = 32;
  localparam int NUM_W      = 48;
  localparam int DEN_W      = 34;
  localparam int DIV_STAGES = NUM_W;
  // register layers from the request edge to the result register
  localparam int LATENCY    = DIV_STAGES + 7;
  localparam int VLD_N      = DIV_STAGES + 6;

  // floor(d / 1000000) as (d * MN_RECIP) >> MN_SHIFT, exact for d < 2^31
  localparam logic [31:0] MN_RECIP = 32'd2251799814;
  localparam int          MN_SHIFT = 51;

  localparam logic signed [31:0] ONE_Q16  = 32'sd65536;
  localparam logic signed [31:0] NEAR_Q16 = 32'sd6554;
  localparam logic signed [31:0] FAR_Q16  = 32'sd6553600;

  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_AXIS    = 3'd1;
  localparam logic [2:0] REG_CAMERA  = 3'd2;
  localparam logic [2:0] REG_ROT0    = 3'd3;
  localparam logic [2:0] REG_ROT1    = 3'd4;
  localparam logic [2:0] REG_ROT2    = 3'd5;
  localparam logic [2:0] REG_ROT3    = 3'd6;

  typedef enum logic [1:0] {
    MODE_PERSP  = 2'd0,
    MODE_ORTHO  = 2'd1,
    MODE_STEREO = 2'd2,
    MODE_BAD    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_AXIS   = 2'd1,
    ST_MODE   = 2'd2,
    ST_CAMERA = 2'd3
  } status_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef coord_t coords_t [MAX_DIMS];

  typedef struct packed {
    logic [3:0] dims_used;
    coord_t     coord0;
    coord_t     coord1;
    coord_t     coord2;
    coord_t     coord3;
    coord_t     coord4;
    coord_t     coord5;
    coord_t     coord6;
    coord_t     coord7;
  } in_t;

  typedef struct packed {
    status_t            status;
    coord_t             out_x;
    coord_t             out_y;
    coord_t             out_z;
    logic signed [31:0] depth;
    logic signed [31:0] scale_factor;
    logic               in_view;
  } out_t;

  // what travels alongside the divider
  typedef struct packed {
    status_t            status;
    mode_t              mode;
    coord_t             pv_x;
    coord_t             pv_y;
    coord_t             pv_z;
    coord_t             pw;
    coord_t             fold;
    logic               fold_en;
    logic               dneg;
  } ctx_t;

  // what travels alongside the axis lanes
  typedef struct packed {
    status_t            status;
    logic signed [31:0] depth;
    logic signed [31:0] factor;
  } tail_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic coords_t unpack_coords(input in_t v);
    coords_t c;
    c[0] = v.coord0;
    c[1] = v.coord1;
    c[2] = v.coord2;
    c[3] = v.coord3;
    c[4] = v.coord4;
    c[5] = v.coord5;
    c[6] = v.coord6;
    c[7] = v.coord7;
    return c;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/fdp_rot_lane.sv =====
// one row of the 4x4 rotation: four products, then sum, round half up, saturate
// depends on fdp_pkg; the four products are registered, then res
`default_nettype none
module fdp_rot_lane (
  input  logic                 clk,
  input  fdp_pkg::coord_t      p4 [4],
  input  logic [63:0]          row,
  output fdp_pkg::coord_t      res
);
  import fdp_pkg::*;

  logic signed [47:0] prod [4];
  logic signed [49:0] acc;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      prod[c] <= p4[c] * $signed(row[16*c +: 16]);
    end
  end

  assign acc = 50'(prod[0]) + 50'(prod[1]) + 50'(prod[2]) + 50'(prod[3]) + 50'sd8192;

  always_ff @(posedge clk) begin
    res <= sat32(64'(acc >>> 14));
  end
endmodule
`default_nettype wire

// ===== rtl/fdp_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, unsigned operands
// depends on fdp_pkg for default widths; every stage is registered and quo is the last one
`default_nettype none
module fdp_divider #(
  parameter int NUM_W = fdp_pkg::NUM_W,
  parameter int DEN_W = fdp_pkg::DEN_W
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);
  logic [DEN_W-1:0] rem_s [NUM_W];
  logic [NUM_W-1:0] num_s [NUM_W];
  logic [DEN_W-1:0] den_s [NUM_W];
  logic [NUM_W-1:0] quo_s [NUM_W];

  for (genvar j = 0; j < NUM_W; j++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [DEN_W-1:0] den_in;
    logic [NUM_W-1:0] quo_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_s[j-1];
      assign num_in = num_s[j-1];
      assign den_in = den_s[j-1];
      assign quo_in = quo_s[j-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      rem_s[j] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
      num_s[j] <= {num_in[NUM_W-2:0], 1'b0};
      den_s[j] <= den_in;
      quo_s[j] <= {quo_in[NUM_W-2:0], ge};
    end
  end

  assign quo = quo_s[NUM_W-1];
endmodule
`default_nettype wire

// ===== rtl/fdp_axis_lane.sv =====
// one output axis: coordinate times factor (floor), saturate, optional fold add
// depends on fdp_pkg; the product is registered, then res
`default_nettype none
module fdp_axis_lane (
  input  logic               clk,
  input  fdp_pkg::coord_t    pv,
  input  logic signed [31:0] factor,
  input  fdp_pkg::coord_t    fold,
  input  logic               fold_en,
  output fdp_pkg::coord_t    res
);
  import fdp_pkg::*;

  logic signed [63:0] prod;
  coord_t             fold_q;
  logic               en_q;
  coord_t             scaled;
  logic signed [32:0] sum;

  always_ff @(posedge clk) begin
    prod   <= 64'(pv) * 64'(factor);
    fold_q <= fold;
    en_q   <= fold_en;
  end

  assign scaled = sat32(prod >>> 16);
  assign sum    = 33'(scaled) + 33'(fold_q);

  always_ff @(posedge clk) begin
    res <= en_q ? sat32(64'(sum)) : scaled;
  end
endmodule
`default_nettype wire

// ===== rtl/four_d_to_three_d_projection.sv =====
// 4d to 3d projection top level: config registers, rotation lanes, divider, axis lanes
// depends on fdp_pkg, fdp_rot_lane, fdp_divider, fdp_axis_lane
// throughput: one request per cycle, busy is low except during reset
// reset (rst, synchronous) clears the config registers to their defaults and drops requests in flight
// results are shown for one cycle on done; the receiver cannot stall
`default_nettype none
module four_d_to_three_d_projection (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  fdp_pkg::in_t  item,
  output logic          done,
  output fdp_pkg::out_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import fdp_pkg::*;

  logic [3:0]  control;
  logic [8:0]  axis_select;
  logic [30:0] cam_dist;
  logic [63:0] rot_row0, rot_row1, rot_row2, rot_row3;
  logic [62:0] mn_prod;
  logic [11:0] mn;

  assign busy   = rst;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      control     <= '0;
      axis_select <= 9'd136;
      cam_dist    <= 31'd196608;
      rot_row0    <= 64'd16384;
      rot_row1    <= 64'd16384 << 16;
      rot_row2    <= 64'd16384 << 32;
      rot_row3    <= 64'd16384 << 48;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[5:3])
        REG_CONTROL: control     <= pwdata[3:0];
        REG_AXIS:    axis_select <= pwdata[8:0];
        REG_CAMERA:  cam_dist    <= pwdata[30:0];
        REG_ROT0:    rot_row0    <= pwdata;
        REG_ROT1:    rot_row1    <= pwdata;
        REG_ROT2:    rot_row2    <= pwdata;
        REG_ROT3:    rot_row3    <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_CONTROL: prdata = {60'b0, control};
      REG_AXIS:    prdata = {55'b0, axis_select};
      REG_CAMERA:  prdata = {33'b0, cam_dist};
      REG_ROT0:    prdata = rot_row0;
      REG_ROT1:    prdata = rot_row1;
      REG_ROT2:    prdata = rot_row2;
      REG_ROT3:    prdata = rot_row3;
      default:     prdata = '0;
    endcase
  end

  // minimum perspective denominator, a register that follows cam_dist in the cycle after
  assign mn_prod = {32'b0, cam_dist} * {31'b0, MN_RECIP};
  always_ff @(posedge clk) begin
    mn <= mn_prod[62:MN_SHIFT] + 12'd1;
  end

  // valid bits along the pipeline
  logic [VLD_N-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[VLD_N-2:0], start && !busy};
      done <= vld[VLD_N-1];
    end
  end

  // stage a: request capture, zero-padded first four coordinates
  in_t        a_item, b_item, c_item;
  logic [3:0] a_dims, b_dims, c_dims;
  coords_t    a_c;
  coord_t     a_p4 [4];

  always_ff @(posedge clk) begin
    a_item <= item;
    a_dims <= (item.dims_used > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : item.dims_used;
    b_item <= a_item;
    b_dims <= a_dims;
    c_item <= b_item;
    c_dims <= b_dims;
  end

  always_comb begin
    a_c = unpack_coords(a_item);
    for (int i = 0; i < 4; i++) begin
      a_p4[i] = (4'(i) < a_dims) ? a_c[i] : '0;
    end
  end

  coord_t      c_r4 [4];
  logic [63:0] rows [4];
  assign rows[0] = rot_row0;
  assign rows[1] = rot_row1;
  assign rows[2] = rot_row2;
  assign rows[3] = rot_row3;

  for (genvar r = 0; r < 4; r++) begin : g_rot
    fdp_rot_lane u_rot (
      .clk (clk),
      .p4  (a_p4),
      .row (rows[r]),
      .res (c_r4[r])
    );
  end

  // stage c: axis selection, status, denominator and fold
  coords_t            c_c;
  coord_t             p4u [4];
  coord_t             p4s [4];
  coord_t             pv [3];
  logic [2:0]         keep [3];
  logic [3:0]         used;
  logic [1:0]         w_axis;
  coord_t             pw;
  logic signed [33:0] pden, sden;
  logic [33:0]        pabs, sabs;
  logic signed [39:0] fsum;
  mode_t              mode;
  status_t            st;
  ctx_t               c_ctx, d_ctx;
  logic [NUM_W-1:0]   c_num, d_num;
  logic [DEN_W-1:0]   c_mag, d_mag;

  assign mode = mode_t'(control[1:0]);

  always_comb begin
    c_c = unpack_coords(c_item);
    for (int i = 0; i < 4; i++) begin
      p4u[i] = (4'(i) < c_dims) ? c_c[i] : '0;
      p4s[i] = control[3] ? c_r4[i] : p4u[i];
    end

    used = '0;
    for (int i = 0; i < 3; i++) begin
      keep[i] = axis_select[3*i +: 3];
      pv[i]   = keep[i][2] ? c_c[keep[i]] : p4s[keep[i][1:0]];
      if (!keep[i][2]) used[keep[i][1:0]] = 1'b1;
    end

    priority if (!used[0]) w_axis = 2'd0;
    else if (!used[1])     w_axis = 2'd1;
    else if (!used[2])     w_axis = 2'd2;
    else                   w_axis = 2'd3;

    pw = ({2'b0, w_axis} < c_dims) ? p4s[w_axis] : '0;

    priority if ({1'b0, keep[0]} >= c_dims || {1'b0, keep[1]} >= c_dims ||
                 {1'b0, keep[2]} >= c_dims)                  st = ST_AXIS;
    else if (mode == MODE_BAD)                                st = ST_MODE;
    else if (mode == MODE_PERSP && cam_dist == '0)            st = ST_CAMERA;
    else                                                      st = ST_OK;

    // perspective: guard keeps the sign and lifts the magnitude to mn
    pden = $signed({3'b0, cam_dist}) - 34'(pw);
    pabs = pden[33] ? 34'(-pden) : 34'(pden);
    // stereographic: zero becomes +1 lsb
    sden = 34'sd65536 - 34'(pw);
    sabs = sden[33] ? 34'(-sden) : 34'(sden);

    if (mode == MODE_PERSP) begin
      c_num = {1'b0, cam_dist, 16'b0};
      c_mag = (pabs < {22'b0, mn}) ? {22'b0, mn} : pabs;
      c_ctx.dneg = pden[33];
    end else begin
      c_num = NUM_W'(64'h1_0000_0000);
      c_mag = (sabs == '0) ? DEN_W'(1) : sabs;
      c_ctx.dneg = sden[33];
    end

    fsum = '0;
    for (int k = 4; k < MAX_DIMS; k++) begin
      if (4'(k) < c_dims) fsum = fsum + (40'(c_c[k]) <<< (10 - k));
    end

    c_ctx.status  = st;
    c_ctx.mode    = mode;
    c_ctx.pv_x    = pv[0];
    c_ctx.pv_y    = pv[1];
    c_ctx.pv_z    = pv[2];
    c_ctx.pw      = pw;
    c_ctx.fold    = 32'(fsum >>> 8);
    c_ctx.fold_en = control[2] && (c_dims > 4'd4);
  end

  always_ff @(posedge clk) begin
    d_ctx <= c_ctx;
    d_num <= c_num;
    d_mag <= c_mag;
  end

  // divider, with the context riding alongside
  logic [NUM_W-1:0] e_quo;
  ctx_t             ctx_pipe [DIV_STAGES];

  fdp_divider #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk (clk),
    .num (d_num),
    .den (d_mag),
    .quo (e_quo)
  );

  always_ff @(posedge clk) begin
    ctx_pipe[0] <= d_ctx;
    for (int j = 1; j < DIV_STAGES; j++) begin
      ctx_pipe[j] <= ctx_pipe[j-1];
    end
  end

  // stage e: factor from the quotient, saturated to q16.16
  ctx_t               e_ctx;
  logic signed [31:0] factor;
  tail_t              e_tail;
  tail_t              tail_pipe [2];

  assign e_ctx = ctx_pipe[DIV_STAGES-1];

  always_comb begin
    if (e_ctx.mode == MODE_ORTHO) begin
      factor = ONE_Q16;
    end else if (!e_ctx.dneg) begin
      factor = (e_quo > NUM_W'(64'h7fff_ffff)) ? 32'sh7fffffff : $signed(e_quo[31:0]);
    end else begin
      factor = (e_quo > NUM_W'(64'h8000_0000)) ? 32'sh80000000 : -$signed(e_quo[31:0]);
    end
    e_tail.status = e_ctx.status;
    e_tail.factor = factor;
    e_tail.depth  = (e_ctx.mode == MODE_ORTHO) ? e_ctx.pw : factor;
  end

  always_ff @(posedge clk) begin
    tail_pipe[0] <= e_tail;
    tail_pipe[1] <= tail_pipe[0];
  end

  coord_t g_x, g_y, g_z;

  fdp_axis_lane u_lane_x (
    .clk (clk), .pv (e_ctx.pv_x), .factor (factor),
    .fold (e_ctx.fold), .fold_en (e_ctx.fold_en), .res (g_x)
  );
  fdp_axis_lane u_lane_y (
    .clk (clk), .pv (e_ctx.pv_y), .factor (factor),
    .fold (e_ctx.fold), .fold_en (e_ctx.fold_en), .res (g_y)
  );
  fdp_axis_lane u_lane_z (
    .clk (clk), .pv (e_ctx.pv_z), .factor (factor),
    .fold (e_ctx.fold), .fold_en (e_ctx.fold_en), .res (g_z)
  );

  // merge: frustum test, errors force every other field to zero
  tail_t g_tail;
  logic  g_inside;
  out_t  g_out;

  assign g_tail = tail_pipe[1];

  always_comb begin
    g_inside = (g_x <= ONE_Q16) && (g_x >= -ONE_Q16) &&
               (g_y <= ONE_Q16) && (g_y >= -ONE_Q16) &&
               (g_z <= ONE_Q16) && (g_z >= -ONE_Q16) &&
               (g_tail.depth >= NEAR_Q16) && (g_tail.depth <= FAR_Q16);
    g_out = '0;
    g_out.status = g_tail.status;
    if (g_tail.status == ST_OK) begin
      g_out.out_x        = g_x;
      g_out.out_y        = g_y;
      g_out.out_z        = g_z;
      g_out.depth        = g_tail.depth;
      g_out.scale_factor = g_tail.factor;
      g_out.in_view      = g_inside;
    end
  end

  always_ff @(posedge clk) begin
    result <= g_out;
  end
endmodule
`default_nettype wire

// ===== rtl/fdp_checker.sv =====
// port-level checks for the projection block, bound to the top level
// depends on fdp_pkg and four_d_to_three_d_projection
`default_nettype none
module fdp_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input fdp_pkg::out_t result
);
  import fdp_pkg::*;

  // every result goes back to a request a fixed latency earlier
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  // an error result carries nothing else
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |->
      (result.out_x == '0 && result.out_y == '0 && result.out_z == '0 &&
       result.depth == '0 && result.scale_factor == '0 && !result.in_view))
    else $error("error result with nonzero fields");

  // frustum flag agrees with the reported coordinates and depth
  a_frustum: assert property (@(posedge clk) disable iff (rst)
    (done && result.in_view) |->
      (result.out_x <= ONE_Q16 && result.out_x >= -ONE_Q16 &&
       result.out_y <= ONE_Q16 && result.out_y >= -ONE_Q16 &&
       result.out_z <= ONE_Q16 && result.out_z >= -ONE_Q16 &&
       result.depth >= NEAR_Q16 && result.depth <= FAR_Q16))
    else $error("frustum flag inconsistent with result");
endmodule

bind four_d_to_three_d_projection fdp_checker u_fdp_checker (.*);
`default_nettype wire
